/* sv/hough_line_vote_accumulator_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the Hough line vote accumulator
// Each macro places one labeled concurrent check on clk, off while rst_n low.
// ---------------------------------------------------------------------------
`ifndef HOUGH_LINE_VOTE_ACCUMULATOR_UNIT_DEFINES_SVH
`define HOUGH_LINE_VOTE_ACCUMULATOR_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define HLVA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HLVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hlva_pkg.sv */
// ---------------------------------------------------------------------------
// hlva_pkg
// Shared constants, codes, command type and trig table helpers.
// ---------------------------------------------------------------------------
package hlva_pkg;

  localparam int ANGLE_STEPS_DEF        = 180;
  localparam int DISTANCE_BINS_DEF      = 2048;
  localparam int TRIG_FRACTION_BITS_DEF = 15;

  localparam int MAX_SIDE    = 1024;
  localparam int COUNT_W     = 15;
  localparam int POS_W       = 10;
  localparam int SIDE_W      = 11;
  localparam int THR_W       = 8;
  localparam int OP_W        = 2;
  localparam int ROW_IN_W    = 9;
  localparam int IDX_IN_W    = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // opcodes, also used as the command kind
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_VOTE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_MAX   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic [OP_W-1:0]     kind;
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [ROW_IN_W-1:0] row;
    logic [IDX_IN_W-1:0] idx;
  } hlva_cmd_t;

  // first-quadrant sine of a whole degree, Q30, by Taylor series
  function automatic longint unsigned quad_sine_q30(input int unsigned a);
    longint unsigned x;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    x    = (longint'(a) * PI_Q30 + 64'd90) / 180;
    term = x;
    pos  = 0;
    neg  = 0;
    for (int k = 0; k < 11; k++) begin
      if (k % 2 == 0) pos = pos + term;
      else            neg = neg + term;
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (k)
        0:       term = term / 6;
        1:       term = term / 20;
        2:       term = term / 42;
        3:       term = term / 72;
        4:       term = term / 110;
        5:       term = term / 156;
        6:       term = term / 210;
        7:       term = term / 272;
        8:       term = term / 342;
        9:       term = term / 420;
        default: term = term / 506;
      endcase
    end
    if (neg >= pos) return 64'd0;
    pos = pos - neg;
    if (pos > (64'd1 << 30)) pos = 64'd1 << 30;
    return pos;
  endfunction

  // signed sine of any whole degree with f fraction bits, rounded to nearest
  function automatic longint deg_sine(input int unsigned d, input int unsigned f);
    int unsigned     dm;
    int unsigned     a;
    bit              negative;
    longint unsigned v;
    dm       = d % 360;
    negative = 1'b0;
    if (dm <= 90)       a = dm;
    else if (dm <= 180) a = 180 - dm;
    else if (dm <= 270) begin
      a        = dm - 180;
      negative = 1'b1;
    end else begin
      a        = 360 - dm;
      negative = 1'b1;
    end
    v = quad_sine_q30(a);
    v = (v + (64'd1 << (29 - f))) >> (30 - f);
    return negative ? -longint'(v) : longint'(v);
  endfunction

endpackage

/* sv/hlva_ifs.sv */
// ---------------------------------------------------------------------------
// hlva channel interfaces
// Valid/ready channels for pixel commands, results and register writes.
// ---------------------------------------------------------------------------
interface hlva_in_if;
  import hlva_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [THR_W-1:0]    pixel_value;
  logic [ROW_IN_W-1:0] angle_row;
  logic [IDX_IN_W-1:0] distance_index;
  modport source (output valid, opcode, pixel_value, angle_row, distance_index,
                  input ready);
  modport sink (input valid, opcode, pixel_value, angle_row, distance_index,
                output ready);
endinterface

interface hlva_out_if;
  import hlva_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count_value;
  logic               is_maximum;
  modport source (output valid, count_value, is_maximum, input ready);
  modport sink (input valid, count_value, is_maximum, output ready);
endinterface

interface hlva_cfg_if;
  import hlva_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/hlva_front.sv */
// ---------------------------------------------------------------------------
// hlva_front
// Register file, raster position tracking and command classification.
// ---------------------------------------------------------------------------
module hlva_front (
  input  logic               clk,
  input  logic               rst_n,
  hlva_in_if.sink            in_ch,
  hlva_cfg_if.sink           cfg_ch,
  input  logic               hold_i,
  input  logic               q_ready_i,
  output logic               push_o,
  output hlva_pkg::hlva_cmd_t cmd_o
);
  import hlva_pkg::*;

  logic [THR_W-1:0]  thr_r;
  logic [SIDE_W-1:0] width_r;
  logic [SIDE_W-1:0] height_r;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic [SIDE_W-1:0] row_r, row_nxt;

  logic [SIDE_W-1:0] w_eff;
  logic [SIDE_W-1:0] h_eff;
  logic              in_frame;
  logic              votes;
  logic              wrap;
  logic              accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !hold_i && q_ready_i;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    if (width_r == '0)                     w_eff = SIDE_W'(1);
    else if (width_r > SIDE_W'(MAX_SIDE))  w_eff = SIDE_W'(MAX_SIDE);
    else                                   w_eff = width_r;
    if (height_r > SIDE_W'(MAX_SIDE))      h_eff = SIDE_W'(MAX_SIDE);
    else                                   h_eff = height_r;
  end

  assign in_frame = row_r < h_eff;
  assign votes    = in_frame && ({1'b0, col_r} < w_eff) && (in_ch.pixel_value > thr_r);
  assign wrap     = ({1'b0, col_r} + SIDE_W'(1)) >= w_eff;

  always_comb begin
    cmd_o.kind = in_ch.opcode;
    cmd_o.x    = col_r;
    cmd_o.y    = row_r[POS_W-1:0];
    cmd_o.row  = in_ch.angle_row;
    cmd_o.idx  = in_ch.distance_index;
  end

  always_comb begin
    push_o  = 1'b0;
    col_nxt = col_r;
    row_nxt = row_r;
    case (in_ch.opcode)
      OP_CLEAR: begin
        push_o  = accept;
        col_nxt = '0;
        row_nxt = '0;
      end
      OP_VOTE: begin
        // drop pixels at or below threshold, or outside the frame, here; only voting pixels are queued
        push_o = accept && votes;
        if (in_frame) begin
          if (wrap) begin
            col_nxt = '0;
            row_nxt = row_r + SIDE_W'(1);
          end else begin
            col_nxt = col_r + POS_W'(1);
          end
        end
      end
      OP_READ:  push_o = accept;
      OP_MAX:   push_o = accept;
      default:  push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= '0;
      width_r  <= SIDE_W'(512);
      height_r <= SIDE_W'(512);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_THRESHOLD: thr_r    <= cfg_ch.data[THR_W-1:0];
          CFG_WIDTH:     width_r  <= cfg_ch.data;
          CFG_HEIGHT:    height_r <= cfg_ch.data;
          default:       thr_r    <= thr_r;
        endcase
      end
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

/* sv/hlva_queue.sv */
// ---------------------------------------------------------------------------
// hlva_queue
// Short command FIFO between classification and the vote engine.
// ---------------------------------------------------------------------------
module hlva_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  hlva_pkg::hlva_cmd_t cmd_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               pop_i,
  output hlva_pkg::hlva_cmd_t cmd_o
);
  import hlva_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  hlva_cmd_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign ready_o = cnt_r < CNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_r != '0;
  assign cmd_o   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) slot_r[wr_ptr_r] <= cmd_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop_i)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push_i && !pop_i)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop_i && !push_i) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

/* sv/hlva_back.sv */
// ---------------------------------------------------------------------------
// hlva_back
// Vote engine: accumulator memory, per-angle vote pipeline, clear sweep,
// readout and result register.
// ---------------------------------------------------------------------------
`include "hough_line_vote_accumulator_unit_defines.svh"

module hlva_back #(
  parameter int ANGLE_STEPS        = hlva_pkg::ANGLE_STEPS_DEF,
  parameter int DISTANCE_BINS      = hlva_pkg::DISTANCE_BINS_DEF,
  parameter int TRIG_FRACTION_BITS = hlva_pkg::TRIG_FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid_i,
  input  hlva_pkg::hlva_cmd_t q_cmd_i,
  output logic               pop_o,
  output logic               clearing_o,
  hlva_out_if.source         out_ch
);
  import hlva_pkg::*;

  localparam int ROWS      = 2 * ANGLE_STEPS;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int IDX_W     = $clog2(DISTANCE_BINS);
  localparam int TH_W      = (ANGLE_STEPS > 1) ? $clog2(ANGLE_STEPS) : 1;
  localparam int ADDR_W    = ROW_W + IDX_W;
  localparam int MEM_DEPTH = ROWS * (2 ** IDX_W);
  localparam int TRIG_W    = TRIG_FRACTION_BITS + 2;
  localparam int PROD_W    = TRIG_W + POS_W + 1;
  localparam int DIFF_W    = PROD_W + 1;
  localparam int MAG_W     = DIFF_W - TRIG_FRACTION_BITS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_VOTE  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_READW = 3'd4;

  typedef logic signed [TRIG_W-1:0] trig_tab_t [ANGLE_STEPS];

  function automatic trig_tab_t build_tab(input bit use_cos);
    trig_tab_t tab;
    for (int t = 0; t < ANGLE_STEPS; t++)
      tab[t] = TRIG_W'(deg_sine(use_cos ? t + 90 : t, TRIG_FRACTION_BITS));
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_tab(1'b0);
  localparam trig_tab_t COS_TAB = build_tab(1'b1);

  logic [COUNT_W-1:0] mem [MEM_DEPTH];

  logic [2:0]         st_r;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic [TH_W-1:0]    t_r;
  logic [POS_W-1:0]   x_r, y_r;
  logic [COUNT_W-1:0] max_r;
  logic               oor_r;

  logic                     v1_r;
  logic [TH_W-1:0]          t1_r;
  logic signed [PROD_W-1:0] px_r, py_r;
  logic                     v2_r, ok2_r;
  logic [ROW_W-1:0]         row2_r;
  logic [IDX_W-1:0]         idx2_r;
  logic                     v3_r, ok3_r;
  logic [ROW_W-1:0]         row3_r;
  logic [IDX_W-1:0]         idx3_r;

  logic [COUNT_W-1:0] rdata_r;
  logic [ADDR_W-1:0]  raddr;
  logic [ADDR_W-1:0]  waddr;
  logic [COUNT_W-1:0] wdata;
  logic               we;

  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_max_r;
  logic               out_load;

  logic signed [POS_W:0]    xs, ys;
  logic signed [DIFF_W-1:0] diff, absv;
  logic [MAG_W-1:0]         mag;
  logic                     neg;
  logic [COUNT_W-1:0]       bumped;
  logic                     read_oor;
  logic                     needs_out;

  assign clearing_o = st_r == ST_CLEAR;

  // take the next command only with the vote pipeline empty
  assign needs_out = (q_cmd_i.kind == OP_READ) || (q_cmd_i.kind == OP_MAX);
  assign pop_o     = q_valid_i && (st_r == ST_IDLE) && !(needs_out && out_valid_r);

  // load the result register from a read or a maximum readout
  assign out_load = (st_r == ST_READW) || (pop_o && (q_cmd_i.kind == OP_MAX));

  assign read_oor = (32'(q_cmd_i.row) >= ROWS) || (32'(q_cmd_i.idx) >= DISTANCE_BINS);

  // stage 1 operands
  assign xs = $signed({1'b0, x_r});
  assign ys = $signed({1'b0, y_r});

  // stage 2: rho, sign fold, bin range
  assign diff = DIFF_W'(px_r) - DIFF_W'(py_r);
  assign neg  = diff[DIFF_W-1];
  assign absv = neg ? -diff : diff;
  assign mag  = absv[DIFF_W-1:TRIG_FRACTION_BITS];

  // stage 4: saturating increment
  assign bumped = (rdata_r == COUNT_MAX) ? rdata_r : rdata_r + COUNT_W'(1);

  always_comb begin
    if (st_r == ST_IDLE)
      raddr = {ROW_W'(q_cmd_i.row), IDX_W'(q_cmd_i.idx)};
    else
      raddr = {row2_r, idx2_r};
    if (st_r == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wdata = '0;
    end else begin
      we    = v3_r && ok3_r;
      waddr = {row3_r, idx3_r};
      wdata = bumped;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  // vote pipeline payload
  always_ff @(posedge clk) begin
    t1_r   <= t_r;
    px_r   <= xs * SIN_TAB[t_r];
    py_r   <= ys * COS_TAB[t_r];
    row2_r <= (neg && (mag != '0)) ? ROW_W'(t1_r) + ROW_W'(ANGLE_STEPS) : ROW_W'(t1_r);
    idx2_r <= mag[IDX_W-1:0];
    ok2_r  <= mag < MAG_W'(DISTANCE_BINS);
    row3_r <= row2_r;
    idx3_r <= idx2_r;
    ok3_r  <= ok2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_addr_r  <= '0;
      t_r         <= '0;
      max_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= st_r == ST_VOTE;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (we && (st_r != ST_CLEAR) && (bumped > max_r)) max_r <= bumped;

      case (st_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == ADDR_W'(MEM_DEPTH - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (pop_o) begin
            case (q_cmd_i.kind)
              OP_CLEAR: begin
                st_r       <= ST_CLEAR;
                clr_addr_r <= '0;
                max_r      <= '0;
              end
              OP_VOTE: begin
                st_r <= ST_VOTE;
                t_r  <= '0;
                x_r  <= q_cmd_i.x;
                y_r  <= q_cmd_i.y;
              end
              OP_READ: begin
                st_r  <= ST_READW;
                oor_r <= read_oor;
              end
              OP_MAX: begin
                out_count_r <= max_r;
                out_max_r   <= 1'b1;
              end
              default: st_r <= ST_IDLE;
            endcase
          end
        end
        ST_VOTE: begin
          t_r <= t_r + TH_W'(1);
          if (t_r == TH_W'(ANGLE_STEPS - 1)) st_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!v1_r && !v2_r && !v3_r) st_r <= ST_IDLE;
        end
        ST_READW: begin
          out_count_r <= oor_r ? '0 : rdata_r;
          out_max_r   <= 1'b0;
          st_r        <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.count_value = out_count_r;
  assign out_ch.is_maximum  = out_max_r;

  `HLVA_ASSERT_NOW(a_pop_drained, pop_o, !v1_r && !v2_r && !v3_r, "command taken with votes in flight")
  `HLVA_ASSERT_NEXT(a_max_no_fall, (st_r != ST_CLEAR) && !(pop_o && (q_cmd_i.kind == OP_CLEAR)), max_r >= $past(max_r), "running maximum fell without a clear")
  `HLVA_ASSERT_NOW(a_readw_out_free, st_r == ST_READW, !out_valid_r, "read data would overwrite a pending result")
  `HLVA_ASSERT_NOW(a_vote_row_range, v3_r && ok3_r, 32'(row3_r) < ROWS, "vote written beyond the last row")

endmodule

/* sv/hough_line_vote_accumulator_unit.sv */
// ---------------------------------------------------------------------------
// hough_line_vote_accumulator_unit
// Hough line accumulator: raster pixel votes, clear and readout.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : commands. opcode 0 clears the table, 1 feeds the next raster
//            pixel, 2 reads entry (angle_row, distance_index), 3 reads the
//            running maximum. Only opcodes 2 and 3 return a result.
//   out_ch : one transfer per read; is_maximum marks the maximum readout.
//   cfg_ch : register writes (threshold, width, height), always ready.
// Vote engine:
//   A foreground pixel is taken in IDLE, VOTE runs one read-modify-write per
//   angle on the single accumulator memory, and DRAIN waits for the pipeline
//   to empty; background pixels are dropped at the front. A read loads the
//   result register from READW, the maximum as the engine takes it. A clear
//   sweeps all 2*ANGLE_STEPS*2^ceil(log2 DISTANCE_BINS) entries, one a cycle
//   (737280 at default size), and in_ch is held off then.
// Reset:
//   Registers return to threshold 0, 512 x 512, position to the origin, and
//   the same clearing sweep runs before the first command is taken.
// Stalls:
//   A two-entry command queue decouples input from the engine; a stalled
//   out_ch holds the result register and the engine waits at the next readout.
// ---------------------------------------------------------------------------
module hough_line_vote_accumulator_unit #(
  parameter int ANGLE_STEPS        = hlva_pkg::ANGLE_STEPS_DEF,
  parameter int DISTANCE_BINS      = hlva_pkg::DISTANCE_BINS_DEF,
  parameter int TRIG_FRACTION_BITS = hlva_pkg::TRIG_FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hlva_in_if.sink    in_ch,
  hlva_out_if.source out_ch,
  hlva_cfg_if.sink   cfg_ch
);
  import hlva_pkg::*;

  hlva_cmd_t push_cmd;
  hlva_cmd_t head_cmd;
  logic      push;
  logic      q_ready;
  logic      q_valid;
  logic      pop;
  logic      clearing;

  // front: registers, raster position, classify each transfer
  hlva_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .hold_i    (clearing),
    .q_ready_i (q_ready),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // queue: lets the front keep taking commands while the engine votes
  hlva_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (head_cmd)
  );

  // back: memory, angle sweep, clear pass and result register
  hlva_back #(
    .ANGLE_STEPS        (ANGLE_STEPS),
    .DISTANCE_BINS      (DISTANCE_BINS),
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid_i  (q_valid),
    .q_cmd_i    (head_cmd),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_ch     (out_ch)
  );

endmodule
